// ===== rtl/mcpp_pkg.sv =====
package mcpp_pkg;

	// Field widths
	localparam int BYTE_W = 8;
	localparam int KIND_W = 4;
	localparam int NIB_W  = 4;
	localparam int SLOT_W = 3;
	localparam int VAL_W  = 16;
	localparam int LEN_W  = 28;
	localparam int ERR_W  = 2;
	localparam int PH_W   = 4;
	localparam int LBC_W  = 2;

	// Longest remaining-length field, in bytes (1 to 4)
	localparam int MAX_LENGTH_BYTES = 4;

	// Byte labels
	localparam logic [KIND_W-1:0] KIND_HEADER    = 4'd0;
	localparam logic [KIND_W-1:0] KIND_LENGTH    = 4'd1;
	localparam logic [KIND_W-1:0] KIND_PNAME     = 4'd2;
	localparam logic [KIND_W-1:0] KIND_LEVEL     = 4'd3;
	localparam logic [KIND_W-1:0] KIND_FLAGS     = 4'd4;
	localparam logic [KIND_W-1:0] KIND_KEEPALIVE = 4'd5;
	localparam logic [KIND_W-1:0] KIND_STRLEN    = 4'd6;
	localparam logic [KIND_W-1:0] KIND_STRDATA   = 4'd7;
	localparam logic [KIND_W-1:0] KIND_ID        = 4'd8;
	localparam logic [KIND_W-1:0] KIND_QOS       = 4'd9;
	localparam logic [KIND_W-1:0] KIND_BODY      = 4'd10;

	// String slots
	localparam logic [SLOT_W-1:0] SLOT_CLIENT_ID  = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_WILL_TOPIC = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_WILL_MSG   = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_USER       = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_PASSWORD   = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_TOPIC      = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_FILTER     = 3'd6;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
	localparam logic [ERR_W-1:0] ERR_QOS  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_LEN  = 2'd2;

	// Control packet types
	localparam logic [NIB_W-1:0] TYPE_CONNECT     = 4'd1;
	localparam logic [NIB_W-1:0] TYPE_PUBLISH     = 4'd3;
	localparam logic [NIB_W-1:0] TYPE_PUBACK      = 4'd4;
	localparam logic [NIB_W-1:0] TYPE_SUBSCRIBE   = 4'd8;
	localparam logic [NIB_W-1:0] TYPE_UNSUBSCRIBE = 4'd10;
	localparam logic [NIB_W-1:0] TYPE_UNSUBACK    = 4'd11;

	// CONNECT flag bits
	localparam int CF_WILL_BIT = 2;
	localparam int CF_PASS_BIT = 6;
	localparam int CF_USER_BIT = 7;

	// Parser phases
	localparam logic [PH_W-1:0] PH_HEADER     = 4'd0;
	localparam logic [PH_W-1:0] PH_LENGTH     = 4'd1;
	localparam logic [PH_W-1:0] PH_PNAME_LEN  = 4'd2;
	localparam logic [PH_W-1:0] PH_PNAME_DATA = 4'd3;
	localparam logic [PH_W-1:0] PH_LEVEL      = 4'd4;
	localparam logic [PH_W-1:0] PH_CFLAGS     = 4'd5;
	localparam logic [PH_W-1:0] PH_KEEPALIVE  = 4'd6;
	localparam logic [PH_W-1:0] PH_STRLEN     = 4'd7;
	localparam logic [PH_W-1:0] PH_STRDATA    = 4'd8;
	localparam logic [PH_W-1:0] PH_ID         = 4'd9;
	localparam logic [PH_W-1:0] PH_QOS        = 4'd10;
	localparam logic [PH_W-1:0] PH_BODY       = 4'd11;

	// One result beat
	typedef struct packed {
		logic [KIND_W-1:0] byte_kind;
		logic [NIB_W-1:0]  packet_type;
		logic [NIB_W-1:0]  packet_flags;
		logic [SLOT_W-1:0] string_slot;
		logic [VAL_W-1:0]  field_value;
		logic              field_done;
		logic [LEN_W-1:0]  decoded_length;
		logic              packet_end;
		logic [ERR_W-1:0]  error_code;
	} mcpp_result_t;

endpackage

// ===== rtl/mcpp_byte_if.sv =====
interface mcpp_byte_if import mcpp_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/mcpp_result_if.sv =====
interface mcpp_result_if import mcpp_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] byte_kind;
	logic [NIB_W-1:0]  packet_type;
	logic [NIB_W-1:0]  packet_flags;
	logic [SLOT_W-1:0] string_slot;
	logic [VAL_W-1:0]  field_value;
	logic              field_done;
	logic [LEN_W-1:0]  decoded_length;
	logic              packet_end;
	logic [ERR_W-1:0]  error_code;

	modport source (output valid, output byte_kind, output packet_type, output packet_flags,
		output string_slot, output field_value, output field_done, output decoded_length,
		output packet_end, output error_code, input ready);
	modport sink (input valid, input byte_kind, input packet_type, input packet_flags,
		input string_slot, input field_value, input field_done, input decoded_length,
		input packet_end, input error_code, output ready);
endinterface

// ===== rtl/mcpp_parse_core.sv =====
module mcpp_parse_core import mcpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [BYTE_W-1:0] data_byte,
	output mcpp_result_t      result
);

	// Parser state
	logic [PH_W-1:0]   phase_q, phase_n;
	logic [2*NIB_W-1:0] tf_q, tf_n;
	logic [LEN_W-1:0]  acc_q, acc_n;
	logic [LBC_W-1:0]  lbc_q, lbc_n;
	logic [LEN_W-1:0]  bl_q, bl_n;
	logic [BYTE_W-1:0] hold_q, hold_n;
	logic [VAL_W-1:0]  sl_q, sl_n;
	logic [BYTE_W-1:0] cf_q, cf_n;
	logic [SLOT_W-1:0] slot_q, slot_n;
	logic              sub_q, sub_n;

	logic [NIB_W-1:0]  ptype;
	logic [LEN_W-1:0]  acc_sum;
	logic [VAL_W-1:0]  pair_val;
	logic [VAL_W-1:0]  sl_dec;
	logic              more;
	logic              body;
	logic [LEN_W-1:0]  bl_dec;
	logic [PH_W-1:0]   as_ph;
	logic [SLOT_W-1:0] as_slot;
	logic [PH_W-1:0]   al_ph;
	logic [SLOT_W-1:0] al_slot;

	assign ptype    = tf_q[2*NIB_W-1:NIB_W];
	assign more     = data_byte[BYTE_W-1];
	assign acc_sum  = acc_q + (LEN_W'(data_byte[BYTE_W-2:0]) << (5'(lbc_q) * 5'd7));
	assign pair_val = {hold_q, data_byte};
	assign sl_dec   = sl_q - VAL_W'(1);
	assign bl_dec   = (bl_q != '0) ? bl_q - LEN_W'(1) : '0;

	// Where a finished string leads
	always_comb begin
		as_ph   = PH_BODY;
		as_slot = slot_q;
		priority if (ptype == TYPE_CONNECT) begin
			priority if (slot_q < SLOT_WILL_TOPIC && cf_q[CF_WILL_BIT]) begin
				as_ph = PH_STRLEN; as_slot = SLOT_WILL_TOPIC;
			end else if (slot_q < SLOT_WILL_MSG && cf_q[CF_WILL_BIT]) begin
				as_ph = PH_STRLEN; as_slot = SLOT_WILL_MSG;
			end else if (slot_q < SLOT_USER && cf_q[CF_USER_BIT]) begin
				as_ph = PH_STRLEN; as_slot = SLOT_USER;
			end else if (slot_q < SLOT_PASSWORD && cf_q[CF_PASS_BIT]) begin
				as_ph = PH_STRLEN; as_slot = SLOT_PASSWORD;
			end else begin
				as_ph = PH_BODY;
			end
		end else if (ptype == TYPE_PUBLISH) begin
			as_ph = (tf_q[2:1] != 2'b00) ? PH_ID : PH_BODY;
		end else if (ptype == TYPE_SUBSCRIBE) begin
			as_ph = PH_QOS;
		end else if (ptype == TYPE_UNSUBSCRIBE) begin
			as_ph = PH_STRLEN; as_slot = SLOT_FILTER;
		end else begin
			as_ph = PH_BODY;
		end
	end

	// Where a finished length field leads
	always_comb begin
		al_slot = slot_q;
		priority if (ptype == TYPE_CONNECT) begin
			al_ph = PH_PNAME_LEN;
		end else if (ptype == TYPE_PUBLISH) begin
			al_ph = PH_STRLEN; al_slot = SLOT_TOPIC;
		end else if (ptype >= TYPE_PUBACK && ptype <= TYPE_UNSUBACK) begin
			al_ph = PH_ID;
		end else begin
			al_ph = PH_BODY;
		end
	end

	// Per-byte decode
	always_comb begin
		phase_n = phase_q; tf_n = tf_q; acc_n = acc_q; lbc_n = lbc_q; bl_n = bl_q;
		hold_n = hold_q; sl_n = sl_q; cf_n = cf_q; slot_n = slot_q; sub_n = sub_q;
		result = '0;
		result.byte_kind   = KIND_BODY;
		result.string_slot = SLOT_CLIENT_ID;
		result.field_value = VAL_W'(data_byte);
		result.error_code  = ERR_NONE;
		body = 1'b1;

		unique case (phase_q)
			PH_HEADER: begin
				result.byte_kind = KIND_HEADER;
				tf_n = data_byte; acc_n = '0; lbc_n = '0; bl_n = '0; sub_n = 1'b0;
				phase_n = PH_LENGTH;
				body = 1'b0;
			end
			PH_LENGTH: begin
				result.byte_kind = KIND_LENGTH;
				body = 1'b0;
				acc_n = acc_sum;
				if (more && lbc_q < LBC_W'(MAX_LENGTH_BYTES - 1)) begin
					lbc_n = lbc_q + LBC_W'(1);
				end else begin
					if (more) result.error_code = ERR_LEN;
					bl_n = acc_sum;
					if (acc_sum == '0) begin
						result.packet_end = 1'b1;
						phase_n = PH_HEADER;
					end else begin
						sub_n = 1'b0;
						phase_n = al_ph;
						slot_n = al_slot;
					end
				end
			end
			PH_PNAME_LEN: begin
				result.byte_kind = KIND_PNAME;
				if (!sub_q) begin
					hold_n = data_byte; sub_n = 1'b1;
				end else begin
					sub_n = 1'b0;
					result.field_value = pair_val;
					result.field_done = 1'b1;
					sl_n = pair_val;
					phase_n = (pair_val == '0) ? PH_LEVEL : PH_PNAME_DATA;
				end
			end
			PH_PNAME_DATA: begin
				result.byte_kind = KIND_PNAME;
				sl_n = sl_dec;
				if (sl_dec == '0) phase_n = PH_LEVEL;
			end
			PH_LEVEL: begin
				result.byte_kind = KIND_LEVEL;
				result.field_done = 1'b1;
				phase_n = PH_CFLAGS;
			end
			PH_CFLAGS: begin
				result.byte_kind = KIND_FLAGS;
				result.field_done = 1'b1;
				cf_n = data_byte;
				phase_n = PH_KEEPALIVE;
				sub_n = 1'b0;
			end
			PH_KEEPALIVE: begin
				result.byte_kind = KIND_KEEPALIVE;
				if (!sub_q) begin
					hold_n = data_byte; sub_n = 1'b1;
				end else begin
					sub_n = 1'b0;
					result.field_value = pair_val;
					result.field_done = 1'b1;
					slot_n = SLOT_CLIENT_ID;
					phase_n = PH_STRLEN;
				end
			end
			PH_STRLEN: begin
				result.byte_kind = KIND_STRLEN;
				result.string_slot = slot_q;
				if (!sub_q) begin
					hold_n = data_byte; sub_n = 1'b1;
				end else begin
					sub_n = 1'b0;
					result.field_value = pair_val;
					result.field_done = 1'b1;
					sl_n = pair_val;
					if (pair_val == '0) begin
						phase_n = as_ph; slot_n = as_slot;
					end else begin
						phase_n = PH_STRDATA;
					end
				end
			end
			PH_STRDATA: begin
				result.byte_kind = KIND_STRDATA;
				result.string_slot = slot_q;
				sl_n = sl_dec;
				if (sl_dec == '0) begin
					phase_n = as_ph; slot_n = as_slot; sub_n = 1'b0;
				end
			end
			PH_ID: begin
				result.byte_kind = KIND_ID;
				if (!sub_q) begin
					hold_n = data_byte; sub_n = 1'b1;
				end else begin
					sub_n = 1'b0;
					result.field_value = pair_val;
					result.field_done = 1'b1;
					if (ptype == TYPE_SUBSCRIBE || ptype == TYPE_UNSUBSCRIBE) begin
						phase_n = PH_STRLEN; slot_n = SLOT_FILTER;
					end else begin
						phase_n = PH_BODY;
					end
				end
			end
			PH_QOS: begin
				result.byte_kind = KIND_QOS;
				result.field_done = 1'b1;
				if (data_byte[BYTE_W-1:2] != '0) result.error_code = ERR_QOS;
				phase_n = PH_STRLEN; slot_n = SLOT_FILTER; sub_n = 1'b0;
			end
			default: begin
				result.byte_kind = KIND_BODY;
				phase_n = PH_BODY;
			end
		endcase

		// Count down the remaining length on payload-side bytes
		if (body) begin
			bl_n = bl_dec;
			if (bl_dec == '0) begin
				result.packet_end = 1'b1;
				phase_n = PH_HEADER;
				sub_n = 1'b0;
			end
		end

		result.packet_type    = tf_n[2*NIB_W-1:NIB_W];
		result.packet_flags   = tf_n[NIB_W-1:0];
		result.decoded_length = acc_n;
	end

	// State update, one beat per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; tf_q <= '0; acc_q <= '0; lbc_q <= '0; bl_q <= '0;
			hold_q <= '0; sl_q <= '0; cf_q <= '0; slot_q <= '0; sub_q <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_n; tf_q <= tf_n; acc_q <= acc_n; lbc_q <= lbc_n; bl_q <= bl_n;
			hold_q <= hold_n; sl_q <= sl_n; cf_q <= cf_n; slot_q <= slot_n; sub_q <= sub_n;
		end
	end

endmodule

// ===== rtl/mqtt_control_packet_parser_top.sv =====
// MQTT 3.1.1 control packet parser. Takes one stream byte per beat on pkt and
// returns one labelled result beat per byte on res, in order. A byte is
// registered on entry, decoded combinationally against the parser state and
// registered again on exit; the block sustains one byte every cycle while res
// is ready, and the only feedback loop is the parser state update. A stalled
// result stage holds one result while one more byte waits in the entry
// register.
module mqtt_control_packet_parser_top import mcpp_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	mcpp_byte_if.sink     pkt,
	mcpp_result_if.source res
);

	logic              v_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              v_s2;
	mcpp_result_t      result_s2;
	mcpp_result_t      core_res;
	logic              adv;

	// Stage handshake
	assign adv       = v_s1 && (!v_s2 || res.ready);
	assign pkt.ready = !v_s1 || adv;

	// Entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pkt.ready) begin
			v_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) data_s1 <= pkt.data_byte;
	end

	mcpp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.data_byte (data_s1),
		.result    (core_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (res.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) result_s2 <= core_res;
	end

	assign res.valid          = v_s2;
	assign res.byte_kind      = result_s2.byte_kind;
	assign res.packet_type    = result_s2.packet_type;
	assign res.packet_flags   = result_s2.packet_flags;
	assign res.string_slot    = result_s2.string_slot;
	assign res.field_value    = result_s2.field_value;
	assign res.field_done     = result_s2.field_done;
	assign res.decoded_length = result_s2.decoded_length;
	assign res.packet_end     = result_s2.packet_end;
	assign res.error_code     = result_s2.error_code;

`ifndef ASSERT_OFF
	// A header byte never closes a packet, completes a field or carries a length
	a_header_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && res.byte_kind == KIND_HEADER) |->
		(!res.packet_end && !res.field_done && res.decoded_length == '0))
		else $error("header beat with end, done or length set");

	// QoS error only on a QoS byte, length error only on a length byte
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && res.error_code != ERR_NONE) |->
		((res.error_code == ERR_QOS && res.byte_kind == KIND_QOS) ||
		 (res.error_code == ERR_LEN && res.byte_kind == KIND_LENGTH)))
		else $error("error code on wrong byte kind");

	// Slot is only named on string bytes
	a_slot_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && res.string_slot != SLOT_CLIENT_ID) |->
		(res.byte_kind == KIND_STRLEN || res.byte_kind == KIND_STRDATA))
		else $error("string slot on non-string byte");

	// Entry stage never drops a byte: a held byte advances when output frees
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> v_s1)
		else $error("entry byte lost");
`endif

endmodule
